// ===== rtl/qdec_pkg.sv =====
// Shared types, constants and the transition table of the quadrature decoder.
`default_nettype none
package qdec_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS       = 32;
    localparam int DIV_STEP_W      = $clog2(DIV_STEPS);

    localparam logic [25:0] PER_MINUTE_US = 26'd60000000;
    localparam logic [31:0] SAT_TOTAL     = 32'h8000_0000;
    localparam logic [31:0] SPEED_MAX     = 32'h7FFF_FFFF;

    localparam logic [1:0] FUNC_PINS   = 2'd0;
    localparam logic [1:0] FUNC_REBASE = 2'd1;
    localparam logic [1:0] FUNC_SPEED  = 2'd2;
    localparam logic [1:0] FUNC_LOAD   = 2'd3;

    localparam logic REG_COUNT_MODE   = 1'b0;
    localparam logic REG_MIN_INTERVAL = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    typedef enum logic [1:0] {
        K_PINS   = 2'd0,
        K_REBASE = 2'd1,
        K_SPEED  = 2'd2,
        K_LOAD   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        pin_a;
        logic        pin_b;
        logic        us_tick;
        logic [31:0] new_position;
    } t_item;

    // Index is {new B, new A, old B, old A}.
    function automatic logic signed [2:0] step_lut(input logic [3:0] idx);
        logic signed [2:0] v;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: v = 3'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: v = -3'sd1;
            4'd3, 4'd12: v = 3'sd2;
            4'd6, 4'd9: v = -3'sd2;
            default: v = 3'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qdec_front.sv =====
// Input side: accepts transactions, classifies the request and queues it for the back end.
`default_nettype none
module qdec_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [39:0]          i_s_axis_tdata,
    input  wire logic [1:0]           i_s_axis_tuser,
    output logic                      o_item_valid,
    output qdec_pkg::t_item           o_item,
    input  wire logic                 i_item_pop
);
    import qdec_pkg::*;

    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    t_item              n_item;
    logic               push;
    logic               pop;

    always_comb begin
        case (i_s_axis_tuser)
            FUNC_PINS:   n_item.kind = K_PINS;
            FUNC_REBASE: n_item.kind = K_REBASE;
            FUNC_SPEED:  n_item.kind = K_SPEED;
            default:     n_item.kind = K_LOAD;
        endcase
        n_item.pin_a        = i_s_axis_tdata[0];
        n_item.pin_b        = i_s_axis_tdata[1];
        n_item.us_tick      = i_s_axis_tdata[2];
        n_item.new_position = i_s_axis_tdata[34:3];
    end

    assign o_s_axis_tready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_item_valid    = (r_cnt != '0);
    assign pop             = i_item_pop && o_item_valid;
    assign o_item          = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/qdec_back.sv =====
// Back end: position and delta tracking, speed sequencer with divider, output register.
`default_nettype none
module qdec_back #(
    parameter int COUNT_WIDTH = qdec_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_item_valid,
    input  qdec_pkg::t_item  i_item,
    output logic             o_item_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_position,
    output logic [31:0]      o_delta_count,
    output logic [1:0]       o_direction,
    output logic [31:0]      o_speed
);
    import qdec_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int MW = (CW > 38) ? CW : 38;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_RANGE  = 8'b0000_0100,
        S_MUL_LO = 8'b0000_1000,
        S_MUL_HI = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_FINISH = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state                r_state;
    logic                  r_count_mode;
    logic [31:0]           r_min_interval;
    logic [1:0]            r_prev;
    logic [CW-1:0]         r_pos;
    logic [CW-1:0]         r_dref;
    logic [CW-1:0]         r_sref_pos;
    logic [31:0]           r_sref_time;
    logic [31:0]           r_time;
    logic [31:0]           r_speed;
    logic                  r_moved;
    logic                  r_out_valid;
    logic [CW-1:0]         r_mag;
    logic                  r_neg;
    logic [31:0]           r_elapsed;
    logic [63:0]           r_prod;
    logic [DIV_STEP_W-1:0] r_step;

    logic [CW-1:0]         n_pos;
    logic [CW-1:0]         n_dref;
    logic [1:0]            n_prev;
    logic                  n_moved;
    logic [1:0]            now;
    logic                  step_en;
    logic signed [2:0]     step_val;
    logic signed [63:0]    load64;
    logic [CW-1:0]         delta;
    logic signed [63:0]    pos_wide;
    logic signed [63:0]    delta_wide;
    logic [1:0]            dir;
    logic                  slot_free;
    logic                  pop;
    logic                  out_load;
    logic [31:0]           elapsed;
    logic [CW-1:0]         diff;
    logic [CW-1:0]         mag;
    logic [MW-1:0]         mag_ext;
    logic [37:0]           e36;
    logic [57:0]           prod_lo;
    logic [31:0]           prod_hi;
    logic [32:0]           rem2;
    logic                  q_bit;
    logic [31:0]           rem_next;
    logic [31:0]           total;
    logic [31:0]           speed_calc;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign pop        = (r_state == S_IDLE) && i_item_valid
                        && ((i_item.kind == K_SPEED) || slot_free);
    assign o_item_pop = pop;
    assign out_load   = (pop && (i_item.kind != K_SPEED))
                        || ((r_state == S_EMIT) && slot_free);

    always_comb begin
        n_pos    = r_pos;
        n_dref   = r_dref;
        n_prev   = r_prev;
        n_moved  = r_moved;
        now      = {i_item.pin_b, i_item.pin_a};
        step_en  = 1'b0;
        step_val = step_lut({now, r_prev});
        load64   = 64'($signed(i_item.new_position));
        delta    = r_pos - r_dref;
        if (r_state == S_IDLE) begin
            case (i_item.kind)
                K_PINS: begin
                    if (!r_count_mode) begin
                        step_en = (now != r_prev);
                    end else if (!r_prev[0] && i_item.pin_a) begin
                        step_en  = 1'b1;
                        step_val = i_item.pin_b ? 3'sd1 : -3'sd1;
                    end
                    if (step_en) begin
                        n_pos   = r_pos + CW'($signed(step_val));
                        n_moved = (step_val != 3'sd0);
                    end
                    n_prev = now;
                    delta  = n_pos - r_dref;
                end
                K_REBASE: begin
                    n_dref = r_pos;
                end
                K_LOAD: begin
                    n_pos  = load64[CW-1:0];
                    n_dref = load64[CW-1:0];
                    delta  = '0;
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
        pos_wide   = 64'($signed(n_pos));
        delta_wide = 64'($signed(delta));
        if (delta == '0) begin
            dir = DIR_NONE;
        end else if (delta[CW-1]) begin
            dir = DIR_CCW;
        end else begin
            dir = DIR_CW;
        end
    end

    always_comb begin
        elapsed    = r_time - r_sref_time;
        diff       = r_pos - r_sref_pos;
        mag        = diff[CW-1] ? (CW'(0) - diff) : diff;
        mag_ext    = MW'(r_mag);
        e36        = 38'({r_elapsed, 5'b0}) + 38'({r_elapsed, 2'b0});
        prod_lo    = 58'(mag_ext[31:0]) * 58'(PER_MINUTE_US);
        prod_hi    = 32'(mag_ext[37:32]) * 32'(PER_MINUTE_US);
        rem2       = {r_prod[63:32], r_prod[31]};
        q_bit      = (rem2 >= {1'b0, r_elapsed});
        rem_next   = q_bit ? 32'(rem2 - {1'b0, r_elapsed}) : rem2[31:0];
        total      = (r_prod[31:0] > SAT_TOTAL) ? SAT_TOTAL : r_prod[31:0];
        speed_calc = r_neg ? (32'd0 - total) : (total[31] ? SPEED_MAX : total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count_mode   <= 1'b0;
            r_min_interval <= 32'd10;
            r_prev         <= '0;
            r_pos          <= '0;
            r_dref         <= '0;
            r_sref_pos     <= '0;
            r_sref_time    <= '0;
            r_time         <= '0;
            r_speed        <= '0;
            r_moved        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COUNT_MODE: r_count_mode   <= i_cfg_data[0];
                    default:        r_min_interval <= i_cfg_data;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        if (i_item.us_tick) begin
                            r_time <= r_time + 32'd1;
                        end
                        r_pos   <= n_pos;
                        r_dref  <= n_dref;
                        r_prev  <= n_prev;
                        r_moved <= n_moved;
                        if (i_item.kind == K_SPEED) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (!r_moved) begin
                        r_speed <= '0;
                        r_state <= S_EMIT;
                    end else if (elapsed < r_min_interval) begin
                        r_state <= S_EMIT;
                    end else if (diff == '0) begin
                        r_speed <= '0;
                        r_state <= S_EMIT;
                    end else if (elapsed == '0) begin
                        r_speed     <= '0;
                        r_sref_pos  <= r_pos;
                        r_sref_time <= r_time;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_RANGE;
                    end
                end
                S_RANGE: begin
                    if (mag_ext >= MW'(e36)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: r_state <= S_MUL_HI;
                S_MUL_HI: r_state <= S_DIV;
                S_DIV: begin
                    if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_speed     <= speed_calc;
                    r_sref_pos  <= r_pos;
                    r_sref_time <= r_time;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_CHECK: begin
                r_mag     <= mag;
                r_neg     <= diff[CW-1];
                r_elapsed <= elapsed;
            end
            S_RANGE: begin
                r_prod <= {32'd0, SAT_TOTAL};
            end
            S_MUL_LO: begin
                r_prod <= 64'(prod_lo);
            end
            S_MUL_HI: begin
                r_prod <= r_prod + {prod_hi, 32'd0};
                r_step <= '0;
            end
            S_DIV: begin
                r_prod <= {rem_next, r_prod[30:0], q_bit};
                r_step <= r_step + 1'b1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_position    <= pos_wide[31:0];
            o_delta_count <= delta_wide[31:0];
            o_direction   <= dir;
            o_speed       <= r_speed;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== rtl/quadrature_decoder_with_speed.sv =====
// Top level of the quadrature decoder with position, delta and speed outputs.
//
// Channel   Dir  Handshake                 Contents
// s_axis    in   tvalid/tready             tuser: func; tdata: pin_a, pin_b, us_tick, new_position
// m_axis    out  tvalid/tready             tdata: position, delta_count, direction, speed
// cfg       in   write enable              index 0 count_mode, index 1 min_interval_us
//
// Pin samples, delta reads and position loads are handled in S_IDLE once the output is free.
// A speed request runs S_CHECK and S_EMIT if no division is needed, adds S_RANGE and S_FINISH
// if the result saturates, else also S_MUL_LO, S_MUL_HI and the 32-step restoring divider.
// A two-entry queue takes transactions, until it is full, while the back end is busy or stalled.
// Synchronous reset clears the control state, not the queue entries, divider or output data.
`default_nettype none
module quadrature_decoder_with_speed #(
    parameter int COUNT_WIDTH = qdec_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // pin_a, pin_b, us_tick, new_position[31:0], pad
    input  wire logic [1:0]  i_s_axis_tuser,   // func
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [103:0]     o_m_axis_tdata,   // position, delta_count, direction, speed, pad
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import qdec_pkg::*;

    t_item       item;
    logic        item_valid;
    logic        item_pop;
    logic [31:0] position;
    logic [31:0] delta_count;
    logic [1:0]  direction;
    logic [31:0] speed;

    qdec_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_item_pop      (item_pop)
    );

    qdec_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_pop    (item_pop),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_position    (position),
        .o_delta_count (delta_count),
        .o_direction   (direction),
        .o_speed       (speed)
    );

    assign o_m_axis_tdata = {6'd0, speed, direction, delta_count, position};

endmodule
`default_nettype wire

// ===== dv/qdec_check.sv =====
// Checker that predicts every decoder reading and compares it with the output channel.
`default_nettype none
module qdec_check (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    input  wire logic         i_s_axis_tready,
    input  wire logic [39:0]  i_s_axis_tdata,   // pin_a, pin_b, us_tick, new_position, pad
    input  wire logic [1:0]   i_s_axis_tuser,   // func
    input  wire logic         i_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    input  wire logic [103:0] i_m_axis_tdata,   // position, delta_count, direction, speed, pad
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    import qdec_pkg::*;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] delta;
        logic [1:0]  dir;
        logic [31:0] speed;
    } t_reading;

    t_reading expected_readings[$];
    int mismatches = 0;
    int waiting = 0;

    logic              full_mode;
    logic [31:0]       min_us;
    logic [1:0]        prev_pins;
    logic [31:0]       pos;
    logic [31:0]       delta_ref;
    logic [31:0]       spd_ref_pos;
    logic [31:0]       spd_ref_time;
    logic [31:0]       us_time;
    logic [31:0]       speed;
    logic signed [2:0] last_inc;

    assign o_errors  = mismatches;
    assign o_pending = waiting;

    // Index is {new B, new A, old B, old A}.
    function automatic logic signed [2:0] quarter_increment(input logic [3:0] idx);
        case (idx)
            4'd3, 4'd12:                    return 3'sd2;
            4'd6, 4'd9:                     return -3'sd2;
            4'd1, 4'd7, 4'd8, 4'd14:        return 3'sd1;
            4'd2, 4'd4, 4'd11, 4'd13:       return -3'sd1;
            default:                        return 3'sd0;
        endcase
    endfunction

    function automatic logic [31:0] counts_per_minute(input logic [31:0] diff,
            input logic [31:0] elapsed);
        logic        neg;
        logic [31:0] mag;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] total;
        logic [63:0] neg_total;
        neg  = diff[31];
        mag  = neg ? -diff : diff;
        quot = mag / elapsed;
        rem  = mag % elapsed;
        if (quot >= 64'd36) begin
            total = 64'h8000_0000;
        end else begin
            total = quot * 64'd60000000 + (rem * 64'd60000000) / elapsed;
            if (total > 64'h8000_0000)
                total = 64'h8000_0000;
        end
        neg_total = 64'd0 - total;
        if (neg)
            return neg_total[31:0];
        return (total > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : total[31:0];
    endfunction

    function automatic void refresh_speed();
        logic [31:0] elapsed;
        logic [31:0] diff;
        elapsed = us_time - spd_ref_time;
        diff    = pos - spd_ref_pos;
        if (last_inc == 0) begin
            speed = '0;
        end else if (elapsed >= min_us) begin
            if (diff == 0) begin
                speed = '0;
            end else begin
                speed        = (elapsed == 0) ? 32'd0 : counts_per_minute(diff, elapsed);
                spd_ref_pos  = pos;
                spd_ref_time = us_time;
            end
        end
    endfunction

    function automatic t_reading advance_decoder(input t_kind kind, input logic pin_a,
            input logic pin_b, input logic tick, input logic [31:0] load_value);
        t_reading          r;
        logic [1:0]        now;
        logic signed [2:0] inc;
        logic [31:0]       delta;
        now = {pin_b, pin_a};
        inc = '0;
        if (tick)
            us_time = us_time + 32'd1;
        delta = pos - delta_ref;
        case (kind)
            K_PINS: begin
                if (full_mode) begin
                    if (!prev_pins[0] && pin_a)
                        inc = pin_b ? 3'sd1 : -3'sd1;
                end else if (now != prev_pins) begin
                    inc = quarter_increment({now, prev_pins});
                end
                if (inc != 0) begin
                    pos      = pos + {{29{inc[2]}}, inc};
                    last_inc = inc;
                end
                prev_pins = now;
                delta     = pos - delta_ref;
            end
            K_REBASE: delta_ref = pos;
            K_SPEED:  refresh_speed();
            default: begin
                pos       = load_value;
                delta_ref = pos;
                delta     = '0;
            end
        endcase
        r.position = pos;
        r.delta    = delta;
        r.dir      = (delta == 0) ? DIR_NONE : (delta[31] ? DIR_CCW : DIR_CW);
        r.speed    = speed;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] got,
            input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            full_mode    = 1'b0;
            min_us       = 32'd10;
            prev_pins    = '0;
            pos          = '0;
            delta_ref    = '0;
            spd_ref_pos  = '0;
            spd_ref_time = '0;
            us_time      = '0;
            speed        = '0;
            last_inc     = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_COUNT_MODE)
                    full_mode = i_cfg_data[0];
                else
                    min_us = i_cfg_data;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.position = i_m_axis_tdata[31:0];
                got.delta    = i_m_axis_tdata[63:32];
                got.dir      = i_m_axis_tdata[65:64];
                got.speed    = i_m_axis_tdata[97:66];
                if (expected_readings.size() == 0) begin
                    note_mismatch("unexpected transaction, position", got.position, 32'd0);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.position !== want.position)
                        note_mismatch("position", got.position, want.position);
                    if (got.delta !== want.delta)
                        note_mismatch("delta_count", got.delta, want.delta);
                    if (got.dir !== want.dir)
                        note_mismatch("direction", 32'(got.dir), 32'(want.dir));
                    if (got.speed !== want.speed)
                        note_mismatch("speed", got.speed, want.speed);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_readings.push_back(advance_decoder(t_kind'(i_s_axis_tuser),
                    i_s_axis_tdata[0], i_s_axis_tdata[1], i_s_axis_tdata[2],
                    i_s_axis_tdata[34:3]));
        end
        waiting = expected_readings.size();
    end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Stimulus and verdict for the quadrature decoder with position, delta and speed.
`default_nettype none
module tb;
    import qdec_pkg::*;

    // Pin levels {B, A} of a closed walk that takes every old and new pin pair once.
    localparam logic [31:0] CORNER_WALK = 32'h1B72_3E94;
    localparam int PHASES     = 6;
    localparam int PHASE_SIZE = 165;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [39:0]   s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [103:0]  m_tdata;
    logic          cfg_we;
    logic          cfg_index;
    logic [31:0]   cfg_data;
    int            errors;
    int            pending;

    int            send_idle = 16;
    int            recv_idle = 83;
    logic          hold_req  = 1'b0;
    logic          hold_done = 1'b0;
    logic [1:0]    cur_pins  = 2'b00;
    logic          fwd       = 1'b1;

    always #1 clk = ~clk;

    quadrature_decoder_with_speed dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    qdec_check u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    task automatic put_item(input t_kind kind, input logic [1:0] pins, input logic tick,
            input logic [31:0] load_value);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, load_value, tick, pins[1], pins[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == K_PINS)
            cur_pins = pins;
    endtask

    task automatic random_item();
        int         pick;
        logic [1:0] pins;
        logic [31:0] value;
        logic       tick;
        pick  = $urandom_range(99);
        pins  = 2'($urandom_range(3));
        value = $urandom;
        tick  = 1'($urandom_range(1));
        if (pick < 70) begin
            if ($urandom_range(9) == 0)
                fwd = !fwd;
            // Walk the Gray sequence: toggle A when the phases agree going forward.
            if ($urandom_range(4) != 0)
                pins = cur_pins ^ (((cur_pins[0] == cur_pins[1]) == fwd) ? 2'b01 : 2'b10);
            put_item(K_PINS, pins, tick, value);
        end else if (pick < 80) begin
            put_item(K_SPEED, pins, tick, value);
            if ($urandom_range(2) == 0)
                put_item(K_SPEED, ~pins, 1'b1, value);
        end else if (pick < 90) begin
            put_item(K_REBASE, pins, tick, value);
        end else begin
            case ($urandom_range(7))
                0: value = 32'h7FFF_FFFF;
                1: value = 32'h8000_0000;
                2: value = 32'h0000_0000;
                3: value = 32'hFFFF_FFFF;
                default: ;
            endcase
            put_item(K_LOAD, pins, tick, value);
        end
    endtask

    task automatic wait_quiet();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic        mode;
        logic [31:0] min_interval;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= K_PINS;
        cfg_we    <= 1'b0;
        cfg_index <= REG_COUNT_MODE;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs with the reset configuration.
        put_item(K_SPEED, 2'b11, 1'b1, 32'hFFFF_FFFF);
        put_item(K_LOAD, 2'b10, 1'b0, 32'h7FFF_FFFF);
        for (int i = 0; i < 16; i++)
            put_item(K_PINS, CORNER_WALK[2*i +: 2], 1'(i), 32'h5555_AAAA);
        put_item(K_SPEED, 2'b00, 1'b1, 32'h0);
        put_item(K_SPEED, 2'b01, 1'b0, 32'h0);
        put_item(K_REBASE, 2'b11, 1'b1, 32'hAAAA_5555);
        put_item(K_LOAD, 2'b01, 1'b1, 32'h8000_0000);
        put_item(K_PINS, 2'b10, 1'b0, 32'h0);
        put_item(K_SPEED, 2'b00, 1'b1, 32'h0);
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_quiet();
            mode = 1'(p);
            case (p)
                0, 1:    min_interval = 32'd1;
                2:       min_interval = 32'hFFFF_FFFF;
                3:       min_interval = 32'($urandom_range(20, 2));
                4:       min_interval = 32'd5;
                default: min_interval = 32'd10;
            endcase
            write_reg(REG_COUNT_MODE, {31'd0, mode});
            write_reg(REG_MIN_INTERVAL, min_interval);
            cfg_we <= 1'b0;
            if (p == 2) begin
                send_idle = 83;
                recv_idle = 16;
            end else if (p == 4) begin
                send_idle = 0;
                recv_idle = 0;
                hold_req  = 1'b1;
            end
            for (int i = 0; i < PHASE_SIZE; i++)
                random_item();
            s_tvalid <= 1'b0;
        end

        wait_quiet();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
